// ===== rtl/core/xcfp_pkg.sv =====
// Shared constants, codes and control types for the command frame parser.
`timescale 1ns / 1ps

package xcfp_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int BUF_CAP     = (MAX_PAYLOAD > 32) ? 32 : MAX_PAYLOAD;
    localparam int ADDR_W      = (BUF_CAP > 1) ? $clog2(BUF_CAP) : 1;
    localparam int CNT_W       = $clog2(BUF_CAP + 1);

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 8;
    localparam int STATUS_W    = 2;
    localparam int OP_W        = 2;
    localparam int INDEX_W     = 5;
    localparam int CFG_IDX_W   = 8;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h3C;
    localparam logic [BYTE_W-1:0] READ_RESET   = 8'h01;
    localparam logic [BYTE_W-1:0] WRITE_RESET  = 8'h02;
    localparam logic [BYTE_W-1:0] LIST_RESET   = 8'h03;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIST   = 8'd3;

    localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [OP_W-1:0] OP_LIST  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

    typedef struct packed {
        logic hdr;
        logic op;
        logic target;
        logic len;
        logic data;
        logic check;
        logic replay;
    } xcfp_cmd_t;

    typedef struct packed {
        logic hdr_match;
        logic op_match;
        logic len_zero;
        logic data_last;
        logic out_free;
        logic replay_start;
        logic replay_end;
    } xcfp_status_t;

endpackage

// ===== rtl/core/xcfp_ctrl.sv =====
// Frame parsing state machine: sequences the datapath one byte at a time.
`timescale 1ns / 1ps

module xcfp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  xcfp_pkg::xcfp_status_t st,
    output xcfp_pkg::xcfp_cmd_t    cmd
);
    import xcfp_pkg::*;

    localparam logic [2:0] S_HEADER = 3'd0;
    localparam logic [2:0] S_OP     = 3'd1;
    localparam logic [2:0] S_TARGET = 3'd2;
    localparam logic [2:0] S_LEN    = 3'd3;
    localparam logic [2:0] S_DATA   = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;
    localparam logic [2:0] S_REPLAY = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    always_comb
    begin
        unique case (state_reg)
            S_REPLAY: in_ready = 1'b0;
            S_CHECK:  in_ready = st.out_free;
            default:  in_ready = 1'b1;
        endcase
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_OP:
            begin
                cmd.op = accept;
                if (accept)
                begin
                    state_next = st.op_match ? S_TARGET : S_HEADER;
                end
            end
            S_TARGET:
            begin
                cmd.target = accept;
                if (accept)
                begin
                    state_next = S_LEN;
                end
            end
            S_LEN:
            begin
                cmd.len = accept;
                if (accept)
                begin
                    state_next = st.len_zero ? S_CHECK : S_DATA;
                end
            end
            S_DATA:
            begin
                cmd.data = accept;
                if (accept && st.data_last)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = accept;
                if (accept)
                begin
                    state_next = st.replay_start ? S_REPLAY : S_HEADER;
                end
            end
            S_REPLAY:
            begin
                cmd.replay = 1'b1;
                if (st.replay_end)
                begin
                    state_next = S_HEADER;
                end
            end
            default:
            begin
                cmd.hdr    = accept && st.hdr_match;
                state_next = (accept && st.hdr_match) ? S_OP : S_HEADER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HEADER;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_input_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REPLAY) |-> !in_ready)
        else $error("input taken during replay");

    a_replay_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.check && st.replay_start) |=> (state_reg == S_REPLAY))
        else $error("good frame did not start replay");

    a_replay_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.replay && st.replay_end) |=> (state_reg == S_HEADER))
        else $error("replay did not return to header hunt");

endmodule

// ===== rtl/core/xcfp_datapath.sv =====
// Frame datapath: config registers, held fields, checksum, payload buffer, result register.
`timescale 1ns / 1ps

module xcfp_datapath
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [xcfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [xcfp_pkg::BYTE_W-1:0]        cfg_data,
    input  logic [xcfp_pkg::BYTE_W-1:0]        rx_byte,
    input  xcfp_pkg::xcfp_cmd_t                cmd,
    output xcfp_pkg::xcfp_status_t             st,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [xcfp_pkg::STATUS_W-1:0]      status,
    output logic [xcfp_pkg::OP_W-1:0]          op_kind,
    output logic [xcfp_pkg::BYTE_W-1:0]        target,
    output logic [xcfp_pkg::LEN_W-1:0]         payload_len,
    output logic                               has_payload,
    output logic [xcfp_pkg::INDEX_W-1:0]       byte_index,
    output logic [xcfp_pkg::BYTE_W-1:0]        payload_byte,
    output logic                               last
);
    import xcfp_pkg::*;

    logic [BYTE_W-1:0]   header_reg;
    logic [BYTE_W-1:0]   read_code_reg;
    logic [BYTE_W-1:0]   write_code_reg;
    logic [BYTE_W-1:0]   list_code_reg;

    logic [OP_W-1:0]     op_reg;
    logic [BYTE_W-1:0]   target_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    rem_reg;
    logic [BYTE_W-1:0]   xor_reg;
    logic                ovf_reg;

    logic [BYTE_W-1:0]   store [BUF_CAP];
    logic [BYTE_W-1:0]   rd_data_reg;
    logic                rd_vld_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic [CNT_W-1:0]    ld_idx_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OP_W-1:0]     out_op_reg;
    logic [BYTE_W-1:0]   out_target_reg;
    logic [LEN_W-1:0]    out_len_reg;
    logic                out_has_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_last_reg;

    logic [OP_W-1:0]     op_code;
    logic [LEN_W-1:0]    wr_idx;
    logic                wr_in_cap;
    logic                sum_ok;
    logic                out_free;
    logic                out_load;
    logic                rd_issue;
    logic                ld_last;
    logic                single;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg     <= HEADER_RESET;
            read_code_reg  <= READ_RESET;
            write_code_reg <= WRITE_RESET;
            list_code_reg  <= LIST_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_HEADER: header_reg     <= cfg_data;
                CFG_READ:   read_code_reg  <= cfg_data;
                CFG_WRITE:  write_code_reg <= cfg_data;
                CFG_LIST:   list_code_reg  <= cfg_data;
                default:    ;
            endcase
        end
    end

    // list wins over read, read over write
    always_comb
    begin
        if (rx_byte == list_code_reg)
        begin
            op_code = OP_LIST;
        end
        else if (rx_byte == read_code_reg)
        begin
            op_code = OP_READ;
        end
        else if (rx_byte == write_code_reg)
        begin
            op_code = OP_WRITE;
        end
        else
        begin
            op_code = OP_LIST;
        end
    end

    assign wr_idx    = len_reg - rem_reg;
    assign wr_in_cap = wr_idx < LEN_W'(BUF_CAP);
    assign sum_ok    = (xor_reg == rx_byte);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = cmd.replay && rd_vld_reg && out_free;
    assign rd_issue  = cmd.replay && (LEN_W'(rd_idx_reg) < len_reg)
                       && (!rd_vld_reg || out_load);
    assign ld_last   = (LEN_W'(ld_idx_reg + CNT_W'(1)) == len_reg);
    assign single    = cmd.check && !st.replay_start;

    assign st.hdr_match    = (rx_byte == header_reg);
    assign st.op_match     = (rx_byte == list_code_reg) || (rx_byte == read_code_reg)
                             || (rx_byte == write_code_reg);
    assign st.len_zero     = (rx_byte == '0);
    assign st.data_last    = (rem_reg == LEN_W'(1));
    assign st.out_free     = out_free;
    assign st.replay_start = !ovf_reg && sum_ok && (len_reg != '0);
    assign st.replay_end   = out_load && ld_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg     <= OP_LIST;
            target_reg <= '0;
            len_reg    <= '0;
            rem_reg    <= '0;
            xor_reg    <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.hdr)
            begin
                xor_reg <= rx_byte;
                ovf_reg <= 1'b0;
            end
            if (cmd.op)
            begin
                xor_reg <= xor_reg ^ rx_byte;
                op_reg  <= op_code;
            end
            if (cmd.target)
            begin
                xor_reg    <= xor_reg ^ rx_byte;
                target_reg <= rx_byte;
            end
            if (cmd.len)
            begin
                xor_reg <= xor_reg ^ rx_byte;
                len_reg <= rx_byte;
                rem_reg <= rx_byte;
            end
            if (cmd.data)
            begin
                xor_reg <= xor_reg ^ rx_byte;
                rem_reg <= rem_reg - LEN_W'(1);
                if (!wr_in_cap)
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data && wr_in_cap)
        begin
            store[wr_idx[ADDR_W-1:0]] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rd_data_reg <= store[rd_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
            ld_idx_reg <= '0;
        end
        else if (cmd.check)
        begin
            rd_vld_reg <= 1'b0;
            rd_idx_reg <= '0;
            ld_idx_reg <= '0;
        end
        else
        begin
            if (rd_issue)
            begin
                rd_vld_reg <= 1'b1;
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end
            else if (out_load)
            begin
                rd_vld_reg <= 1'b0;
            end
            if (out_load)
            begin
                ld_idx_reg <= ld_idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (single || out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (single)
        begin
            out_status_reg <= ovf_reg ? ST_OVERFLOW : (sum_ok ? ST_GOOD : ST_BAD_SUM);
            out_op_reg     <= op_reg;
            out_target_reg <= target_reg;
            out_len_reg    <= len_reg;
            out_has_reg    <= 1'b0;
            out_index_reg  <= '0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b1;
        end
        else if (out_load)
        begin
            out_status_reg <= ST_GOOD;
            out_op_reg     <= op_reg;
            out_target_reg <= target_reg;
            out_len_reg    <= len_reg;
            out_has_reg    <= 1'b1;
            out_index_reg  <= INDEX_W'(ld_idx_reg);
            out_byte_reg   <= rd_data_reg;
            out_last_reg   <= ld_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign op_kind      = out_op_reg;
    assign target       = out_target_reg;
    assign payload_len  = out_len_reg;
    assign has_payload  = out_has_reg;
    assign byte_index   = out_index_reg;
    assign payload_byte = out_byte_reg;
    assign last         = out_last_reg;

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        single |=> (out_valid_reg && out_last_reg && !out_has_reg))
        else $error("error or empty frame result not registered");

    a_read_ahead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.replay |-> (ld_idx_reg <= rd_idx_reg) && (LEN_W'(rd_idx_reg) <= len_reg))
        else $error("replay counters out of order");

    a_no_overflow_replay: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.replay |-> !ovf_reg && (len_reg <= LEN_W'(BUF_CAP)))
        else $error("replay of an overflowed frame");

endmodule

// ===== rtl/core/xor_checked_command_frame_parser_top.sv =====
// Top level of the XOR-checked command frame parser.
//
//   channel   handshake               payload
//   input     in_valid / in_ready     rx_byte
//   result    out_valid / out_ready   status, op_kind, target, payload_len,
//                                     has_payload, byte_index, payload_byte, last
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Bytes are taken while in_ready is high; the checksum byte waits until the
// result register is free. A good frame with payload then holds off input
// while it replays: the buffer's registered read port is primed first,
// then one item per cycle; output stalls pause the replay.
// Reset returns to header hunting with default codes; the buffer is not cleared.
`timescale 1ns / 1ps

module xor_checked_command_frame_parser_top
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [xcfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [xcfp_pkg::BYTE_W-1:0]        cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [xcfp_pkg::BYTE_W-1:0]        rx_byte,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [xcfp_pkg::STATUS_W-1:0]      status,
    output logic [xcfp_pkg::OP_W-1:0]          op_kind,
    output logic [xcfp_pkg::BYTE_W-1:0]        target,
    output logic [xcfp_pkg::LEN_W-1:0]         payload_len,
    output logic                               has_payload,
    output logic [xcfp_pkg::INDEX_W-1:0]       byte_index,
    output logic [xcfp_pkg::BYTE_W-1:0]        payload_byte,
    output logic                               last
);
    import xcfp_pkg::*;

    xcfp_cmd_t    cmd;
    xcfp_status_t st;

    assign cfg_ready = 1'b1;

    xcfp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    xcfp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .st           (st),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .op_kind      (op_kind),
        .target       (target),
        .payload_len  (payload_len),
        .has_payload  (has_payload),
        .byte_index   (byte_index),
        .payload_byte (payload_byte),
        .last         (last)
    );

endmodule
